FILE: rtl/dd_pkg.sv
// Shared types, constants and calendar tables for the date difference block.
// No dependencies; imported by dd_ctrl, dd_dpath and the top level.

package dd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // floor(y / 100) for y < 10000 as (y * 5243) >> 19
    localparam int          DIV100_SHIFT = 19;
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;     // capture an input beat
        logic sel;      // 0: first date, 1: second date
        logic clamp;    // clamp year and month
        logic div;      // year / 100
        logic leap;     // leap flag, day clamp, century terms
        logic mul;      // (year - 1) * 365
        logic ord;      // finish ordinal
        logic fin;      // form count into output register
    } cmd_t;

    // Datapath status to the controller
    typedef struct packed {
        logic out_free; // output register can take a result this cycle
    } sts_t;

    // Days in month m (1..12)
    function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] m,
                                              input logic is_leap);
        logic [4:0] len;
        case (m)
            4'd2:    len = is_leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in the year before the first of month m (non-leap)
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            default: n = 9'd334;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/dd_ctrl.sv
// Sequencer for the date difference block: walks both dates through the
// ordinal steps, then hands the count to the output register. Uses dd_pkg.

module dd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  dd_pkg::sts_t  sts,
    output dd_pkg::cmd_t  cmd
);
    import dd_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLAMP = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_LEAP  = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_ORD   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CLAMP;
                    sel_next   = 1'b0;
                end
            end
            ST_CLAMP: state_next = ST_DIV;
            ST_DIV:   state_next = ST_LEAP;
            ST_LEAP:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_ORD;
            ST_ORD:
            begin
                if (sel_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_CLAMP;
                    sel_next   = 1'b1;
                end
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // Commands
    assign in_stall  = (state_reg != ST_IDLE);
    assign cmd.load  = (state_reg == ST_IDLE) && in_valid;
    assign cmd.sel   = sel_reg;
    assign cmd.clamp = (state_reg == ST_CLAMP);
    assign cmd.div   = (state_reg == ST_DIV);
    assign cmd.leap  = (state_reg == ST_LEAP);
    assign cmd.mul   = (state_reg == ST_MUL);
    assign cmd.ord   = (state_reg == ST_ORD);
    assign cmd.fin   = (state_reg == ST_FIN) && sts.out_free;

endmodule

FILE: rtl/dd_dpath.sv
// Datapath for the date difference block: input capture, ordinal arithmetic
// for one date per pass, the difference and the output register. Uses dd_pkg.

module dd_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dd_pkg::cmd_t                 cmd,
    output dd_pkg::sts_t                 sts,
    input  logic [dd_pkg::DAY_W-1:0]     start_day,
    input  logic [dd_pkg::MONTH_W-1:0]   start_month,
    input  logic [dd_pkg::YEAR_W-1:0]    start_year,
    input  logic [dd_pkg::DAY_W-1:0]     end_day,
    input  logic [dd_pkg::MONTH_W-1:0]   end_month,
    input  logic [dd_pkg::YEAR_W-1:0]    end_year,
    input  logic                         include_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [dd_pkg::COUNT_W-1:0]   day_count
);
    import dd_pkg::*;

    // Captured beat
    logic [DAY_W-1:0]   sd_reg, ed_reg;
    logic [MONTH_W-1:0] sm_reg, em_reg;
    logic [YEAR_W-1:0]  sy_reg, ey_reg;
    logic               inc_reg;

    // Per-date working registers
    logic [YEAR_W-1:0]  y_reg, py_reg;
    logic [MONTH_W-1:0] m_reg;
    logic [DAY_W-1:0]   draw_reg, d_reg;
    logic [7:0]         yq_reg;
    logic               leap_reg;
    logic [11:0]        t_reg;
    logic [COUNT_W-1:0] acc_reg;
    logic [COUNT_W-1:0] s_ord_reg, e_ord_reg;

    // Output register
    logic               out_valid_reg;
    logic [COUNT_W-1:0] count_reg;

    // Combinational step results
    logic [YEAR_W-1:0]  y_raw, y_next;
    logic [MONTH_W-1:0] m_raw, m_next;
    logic [26:0]        prod100;
    logic [14:0]        cent_back;
    logic               rem0;
    logic [6:0]         pq;
    logic               leap_next;
    logic [4:0]         len;
    logic [DAY_W-1:0]   d_next;
    logic [11:0]        t_next;
    logic [COUNT_W-1:0] acc_next;
    logic [COUNT_W-1:0] ord_next;
    logic [COUNT_W-1:0] diff;

    // Capture input beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sd_reg  <= start_day;
            sm_reg  <= start_month;
            sy_reg  <= start_year;
            ed_reg  <= end_day;
            em_reg  <= end_month;
            ey_reg  <= end_year;
            inc_reg <= include_end;
        end
    end

    // Clamp year and month of the selected date
    always_comb
    begin
        y_raw = cmd.sel ? ey_reg : sy_reg;
        m_raw = cmd.sel ? em_reg : sm_reg;
        if (y_raw < YEAR_MIN)
            y_next = YEAR_MIN;
        else if (y_raw > YEAR_MAX)
            y_next = YEAR_MAX;
        else
            y_next = y_raw;
        if (m_raw == '0)
            m_next = 4'd1;
        else if (m_raw > MONTH_DEC)
            m_next = MONTH_DEC;
        else
            m_next = m_raw;
    end

    // year / 100 by reciprocal multiply
    assign prod100 = 27'(y_reg) * 27'(DIV100_MUL);

    // Leap rule, day clamp and the py/4 - py/100 + py/400 term
    always_comb
    begin
        cent_back = 15'(yq_reg) * 15'd100;
        rem0      = ({1'b0, y_reg} == cent_back);
        pq        = 7'(yq_reg - 8'(rem0));
        leap_next = ((y_reg[1:0] == 2'b00) && !rem0) || (rem0 && (yq_reg[1:0] == 2'b00));
        len       = month_days(m_reg, leap_next);
        if (draw_reg == '0)
            d_next = 5'd1;
        else if (draw_reg > len)
            d_next = len;
        else
            d_next = draw_reg;
        t_next = py_reg[13:2] - 12'(pq) + 12'(pq[6:2]);
    end

    // (year - 1) * 365 and final ordinal
    assign acc_next = 22'(py_reg) * 22'(DAYS_PER_YEAR);
    assign ord_next = acc_reg + 22'(t_reg) + 22'(days_before(m_reg))
                    + 22'((m_reg > MONTH_FEB) && leap_reg) + 22'(d_reg);

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.clamp)
        begin
            y_reg    <= y_next;
            py_reg   <= y_next - 14'd1;
            m_reg    <= m_next;
            draw_reg <= cmd.sel ? ed_reg : sd_reg;
        end
        if (cmd.div)
        begin
            yq_reg <= prod100[26:DIV100_SHIFT];
        end
        if (cmd.leap)
        begin
            leap_reg <= leap_next;
            d_reg    <= d_next;
            t_reg    <= t_next;
        end
        if (cmd.mul)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.ord)
        begin
            if (cmd.sel)
                e_ord_reg <= ord_next;
            else
                s_ord_reg <= ord_next;
        end
    end

    // Difference, floored at zero, plus include flag
    assign diff = (s_ord_reg < e_ord_reg) ? (e_ord_reg - s_ord_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            count_reg <= diff + 22'(inc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign day_count    = count_reg;

endmodule

FILE: rtl/date_difference_in_days_top.sv
// Date difference in days: top level joining the sequencer and the datapath.
// Depends on dd_pkg, dd_ctrl and dd_dpath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one beat of two Gregorian
//   dates and the include_end flag. Output channel (out_valid / out_stall)
//   returns one beat with day_count per input beat, in order.
//   Out-of-range fields are clamped: year to 1..9999, month to 1..12,
//   day to 1..length of its month.
//   The two dates go through the same ordinal unit one after the other,
//   five steps each (clamp, divide by 100, leap/day clamp, multiply by 365,
//   sum), then a final step writes the difference into the output register.
//   A new beat is not accepted before the result of the last one is written
//   into the output register: in_stall is high from the accept until that write.
//   A waiting result does not block the next beat from being accepted and
//   processed; that beat holds in its last step while out_stall keeps the
//   output register full.
//   Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
//   out_valid; no result is lost or repeated when the receiver stalls.

module date_difference_in_days_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [dd_pkg::DAY_W-1:0]     start_day,
    input  logic [dd_pkg::MONTH_W-1:0]   start_month,
    input  logic [dd_pkg::YEAR_W-1:0]    start_year,
    input  logic [dd_pkg::DAY_W-1:0]     end_day,
    input  logic [dd_pkg::MONTH_W-1:0]   end_month,
    input  logic [dd_pkg::YEAR_W-1:0]    end_year,
    input  logic                         include_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [dd_pkg::COUNT_W-1:0]   day_count
);
    import dd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    dd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    dd_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .start_day   (start_day),
        .start_month (start_month),
        .start_year  (start_year),
        .end_day     (end_day),
        .end_month   (end_month),
        .end_year    (end_year),
        .include_end (include_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .day_count   (day_count)
    );

endmodule
